>>> hdl/assert_macros.svh
// Assertion macros shared by the codec RTL.
// Clocked on clk, disabled while rst_n is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/hfc_pkg.sv
// Shared types and fixed constants of the Huffman codec.
// No dependencies.
package hfc_pkg;

  localparam int SYM_W      = 8;
  localparam int OUT_CODE_W = 24;
  localparam int OUT_LEN_W  = 5;

  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_ENCODE = 2'd1,
    OP_DECODE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic [1:0] KIND_CODE = 2'd0;
  localparam logic [1:0] KIND_SYM  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // sorted node chain controls
  typedef struct packed {
    logic clr;
    logic ins;
    logic pop;
  } q_ctrl_t;

  // code cell row controls
  typedef struct packed {
    logic init;
    logic mark;
    logic merge;
    logic shift;
  } cc_ctrl_t;

endpackage

>>> hdl/hfc_qcell.sv
// One cell of the sorted node chain used for the tree build.
// Depends on hfc_pkg.
module hfc_qcell import hfc_pkg::*; #(
  parameter int W_W = 24,
  parameter int N_W = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  q_ctrl_t        ctrl,
  input  logic [W_W-1:0] key_w,
  input  logic           key_m,
  input  logic [N_W-1:0] key_tag,
  input  logic           lf_v,
  input  logic [W_W-1:0] lf_w,
  input  logic           lf_m,
  input  logic [N_W-1:0] lf_tag,
  input  logic           lf_lt,
  input  logic           rt_v,
  input  logic [W_W-1:0] rt_w,
  input  logic           rt_m,
  input  logic [N_W-1:0] rt_tag,
  output logic           cell_v,
  output logic [W_W-1:0] cell_w,
  output logic           cell_m,
  output logic [N_W-1:0] cell_tag,
  output logic           cell_lt
);

  logic           v_r;
  logic [W_W-1:0] w_r;
  logic           m_r;
  logic [N_W-1:0] tag_r;

  // weight, then leaf before merged; leaves by signed symbol, merged newest first
  function automatic logic key_before(input logic [W_W-1:0] wa, input logic ma,
                                      input logic [N_W-1:0] ta, input logic [W_W-1:0] wb,
                                      input logic mb, input logic [N_W-1:0] tb);
    logic [SYM_W-1:0] sa;
    logic [SYM_W-1:0] sb;
    sa = SYM_W'(ta);
    sb = SYM_W'(tb);
    sa[SYM_W-1] = ~sa[SYM_W-1];
    sb[SYM_W-1] = ~sb[SYM_W-1];
    if (wa != wb) return wa < wb;
    if (ma != mb) return !ma;
    if (!ma) return sa < sb;
    return ta > tb;
  endfunction

  assign cell_lt  = !v_r || key_before(key_w, key_m, key_tag, w_r, m_r, tag_r);
  assign cell_v   = v_r;
  assign cell_w   = w_r;
  assign cell_m   = m_r;
  assign cell_tag = tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ctrl.clr) begin
      v_r <= 1'b0;
    end else if (ctrl.ins && cell_lt) begin
      v_r <= lf_lt ? lf_v : 1'b1;
    end else if (ctrl.pop) begin
      v_r <= rt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins && cell_lt) begin
      if (lf_lt) begin
        w_r   <= lf_w;
        m_r   <= lf_m;
        tag_r <= lf_tag;
      end else begin
        w_r   <= key_w;
        m_r   <= key_m;
        tag_r <= key_tag;
      end
    end else if (ctrl.pop) begin
      w_r   <= rt_w;
      m_r   <= rt_m;
      tag_r <= rt_tag;
    end
  end

endmodule

>>> hdl/hfc_ccell.sv
// One code cell: tracks the subtree holding its symbol and grows its code per merge.
// Depends on hfc_pkg.
module hfc_ccell import hfc_pkg::*; #(
  parameter int N_W = 9,
  parameter int L_W = 5,
  parameter int C_W = 24,
  parameter int ID  = 0
) (
  input  logic           clk,
  input  cc_ctrl_t       ctrl,
  input  logic [N_W-1:0] mark_id,
  input  logic [N_W-1:0] a_id,
  input  logic [N_W-1:0] b_id,
  input  logic [N_W-1:0] m_id,
  input  logic           rt_v,
  input  logic [L_W-1:0] rt_len,
  input  logic [C_W-1:0] rt_bits,
  output logic           cell_v,
  output logic [L_W-1:0] cell_len,
  output logic [C_W-1:0] cell_bits
);

  localparam logic [L_W-1:0] LEN_OVF = L_W'(C_W + 1);
  localparam logic [L_W-1:0] LEN_MAX = L_W'(C_W);
  localparam logic [N_W-1:0] OWN_ID  = N_W'(ID);

  logic           v_r;
  logic [L_W-1:0] len_r;
  logic [C_W-1:0] bits_r;
  logic [N_W-1:0] grp_r;
  logic [L_W-1:0] len_inc;

  // length saturates one past the longest code that can be reported
  assign len_inc   = (len_r == LEN_OVF) ? len_r : len_r + L_W'(1);
  assign cell_v    = v_r;
  assign cell_len  = len_r;
  assign cell_bits = bits_r;

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      v_r    <= 1'b0;
      len_r  <= '0;
      bits_r <= '0;
      grp_r  <= OWN_ID;
    end else if (ctrl.mark && mark_id == OWN_ID) begin
      v_r <= 1'b1;
    end else if (ctrl.merge && (grp_r == a_id || grp_r == b_id)) begin
      grp_r <= m_id;
      len_r <= len_inc;
      if (grp_r == b_id && len_r < LEN_MAX) begin
        bits_r <= bits_r | (C_W'(1) << len_r);
      end
    end else if (ctrl.shift) begin
      v_r    <= rt_v;
      len_r  <= rt_len;
      bits_r <= rt_bits;
    end
  end

endmodule

>>> hdl/two_pass_huffman_codec_core.sv
// Top level of the two-pass Huffman codec: control, memories, cell rows.
// Depends on hfc_pkg, hfc_qcell, hfc_ccell and assert_macros.svh.
//
// Items are taken with start while busy is low; a result shows on the out_ ports
// for one cycle with out_strobe and the receiver cannot stall it. A count reads
// the count memory, then writes it; an encode reads the code memory and a decode
// bit reads the node memory. The first encode or decode after counting or
// clearing first builds the tree: it loads counted symbols into the sorted chain,
// does each merge as two pops from the chain head and one insert, and shifts the
// code row into the code memory.
`include "assert_macros.svh"

module two_pass_huffman_codec_core import hfc_pkg::*; #(
  parameter int SYMBOLS       = 256,
  parameter int COUNT_BITS    = 16,
  parameter int MAX_CODE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [SYM_W-1:0]      in_symbol,
  input  logic                  in_code_bit,
  output logic                  out_strobe,
  output logic [1:0]            out_kind,
  output logic [OUT_CODE_W-1:0] out_code,
  output logic [OUT_LEN_W-1:0]  out_code_length,
  output logic [SYM_W-1:0]      out_decoded_symbol
);

  localparam int IDX_W = $clog2(SYMBOLS);
  localparam int N_W   = $clog2(2 * SYMBOLS);
  localparam int W_W   = COUNT_BITS + IDX_W;
  localparam int L_W   = $clog2(MAX_CODE_BITS + 2);
  localparam int CNT_W = IDX_W + 1;
  localparam int CE_W  = 1 + L_W + MAX_CODE_BITS;

  localparam logic [CNT_W-1:0]      SYM_N    = CNT_W'(SYMBOLS);
  localparam logic [N_W-1:0]        SYM_NODE = N_W'(SYMBOLS);
  localparam logic [SYM_W:0]        SYM_LIM  = (SYM_W + 1)'(SYMBOLS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [L_W-1:0]        LEN_OVF  = L_W'(MAX_CODE_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CNT_RD, ST_CNT_WR, ST_B_INIT, ST_B_LOAD, ST_B_POPA, ST_B_POPB,
    ST_B_INS, ST_B_UNLOAD, ST_ENC_RD, ST_ENC_OUT, ST_DEC_RD, ST_DEC_OUT
  } state_t;

  state_t                  state_r;
  op_t                     op_r;
  logic [SYM_W-1:0]        sym_r;
  logic                    bit_r;
  logic                    built_r;
  logic                    any_leaf_r;
  logic [N_W-1:0]          root_r;
  logic [N_W-1:0]          dn_r;
  logic [CNT_W-1:0]        qn_r;
  logic [CNT_W-1:0]        ld_cnt_r;
  logic                    ld_pv_r;
  logic [IDX_W-1:0]        ld_sym_r;
  logic [IDX_W-1:0]        k_r;
  logic [CNT_W-1:0]        ul_cnt_r;
  logic [N_W-1:0]          a_r;
  logic [N_W-1:0]          b_r;
  logic [W_W-1:0]          wa_r;
  logic [W_W-1:0]          w_r;
  logic                    out_strobe_r;
  logic [1:0]              out_kind_r;
  logic [MAX_CODE_BITS-1:0] out_bits_r;
  logic [L_W-1:0]          out_len_r;
  logic [SYM_W-1:0]        out_dsym_r;

  // memories
  logic [COUNT_BITS-1:0] cnt_mem [SYMBOLS];
  logic [SYMBOLS-1:0]    cnt_vld_r;
  logic [COUNT_BITS-1:0] cnt_q_r;
  logic                  cnt_vq_r;
  logic [2*N_W-1:0]      node_mem [SYMBOLS];
  logic [2*N_W-1:0]      node_q_r;
  logic [CE_W-1:0]       code_mem [SYMBOLS];
  logic [CE_W-1:0]       code_q_r;

  logic                  accept;
  logic                  clear_go;
  logic [IDX_W-1:0]      sym_idx;
  logic [IDX_W-1:0]      cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  cnt_we;
  logic                  in_rng;
  logic                  sym_rng;
  logic                  load_ins;
  logic [N_W-1:0]        m_id;
  logic [N_W-1:0]        nx;
  logic                  cq_v;
  logic [L_W-1:0]        cq_len;
  logic [MAX_CODE_BITS-1:0] cq_bits;

  q_ctrl_t               q_ctrl;
  cc_ctrl_t              cc_ctrl;
  logic [W_W-1:0]        key_w;
  logic                  key_m;
  logic [N_W-1:0]        key_tag;

  logic                  q_v   [SYMBOLS];
  logic [W_W-1:0]        q_w   [SYMBOLS];
  logic                  q_m   [SYMBOLS];
  logic [N_W-1:0]        q_tag [SYMBOLS];
  logic                  q_lt  [SYMBOLS];

  logic                     cc_v    [SYMBOLS];
  logic [L_W-1:0]           cc_len  [SYMBOLS];
  logic [MAX_CODE_BITS-1:0] cc_bits [SYMBOLS];

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign clear_go = accept && (op_t'(in_op) == OP_CLEAR);
  assign sym_idx  = sym_r[IDX_W-1:0];
  assign in_rng   = ({1'b0, in_symbol} < SYM_LIM);
  assign sym_rng  = ({1'b0, sym_r} < SYM_LIM);
  assign cnt_raddr = (state_r == ST_B_LOAD) ? ld_cnt_r[IDX_W-1:0] : sym_idx;
  assign cnt_cur  = cnt_vq_r ? cnt_q_r : '0;
  assign cnt_inc  = cnt_cur + COUNT_BITS'(1);
  assign cnt_we   = (state_r == ST_CNT_WR) && (cnt_cur != CNT_MAX);
  assign load_ins = (state_r == ST_B_LOAD) && ld_pv_r && (cnt_cur != '0);
  assign m_id     = SYM_NODE + N_W'(k_r);
  assign nx       = bit_r ? node_q_r[N_W-1:0] : node_q_r[2*N_W-1:N_W];
  assign cq_v     = code_q_r[CE_W-1];
  assign cq_len   = code_q_r[CE_W-2:MAX_CODE_BITS];
  assign cq_bits  = code_q_r[MAX_CODE_BITS-1:0];

  always_comb begin
    q_ctrl.clr = (state_r == ST_B_INIT);
    q_ctrl.ins = load_ins || (state_r == ST_B_INS);
    q_ctrl.pop = ((state_r == ST_B_POPA) && (qn_r > CNT_W'(1))) || (state_r == ST_B_POPB);
    cc_ctrl.init  = (state_r == ST_B_INIT);
    cc_ctrl.mark  = load_ins;
    cc_ctrl.merge = (state_r == ST_B_INS);
    cc_ctrl.shift = (state_r == ST_B_UNLOAD);
    if (state_r == ST_B_INS) begin
      key_w   = w_r;
      key_m   = 1'b1;
      key_tag = m_id;
    end else begin
      key_w   = W_W'(cnt_cur);
      key_m   = 1'b0;
      key_tag = N_W'(ld_sym_r);
    end
  end

  // count memory with per-entry valid bits
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[sym_idx] <= cnt_inc;
    end
    cnt_q_r  <= cnt_mem[cnt_raddr];
    cnt_vq_r <= cnt_vld_r[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (clear_go) begin
      cnt_vld_r <= '0;
    end else if (cnt_we) begin
      cnt_vld_r[sym_idx] <= 1'b1;
    end
  end

  // merged node children, indexed by merge number
  always_ff @(posedge clk) begin
    if (state_r == ST_B_INS) begin
      node_mem[k_r] <= {a_r, b_r};
    end
    node_q_r <= node_mem[IDX_W'(dn_r - SYM_NODE)];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_B_UNLOAD) begin
      code_mem[ul_cnt_r[IDX_W-1:0]] <= {cc_v[0], cc_len[0], cc_bits[0]};
    end
    code_q_r <= code_mem[sym_idx];
  end

  // sorted node chain
  for (genvar i = 0; i < SYMBOLS; i++) begin : g_q
    logic           lv, llt, lm, rv, rm;
    logic [W_W-1:0] lw, rw;
    logic [N_W-1:0] ltag, rtag;
    if (i == 0) begin : g_first
      assign lv = 1'b0; assign llt = 1'b0; assign lm = 1'b0;
      assign lw = '0;   assign ltag = '0;
    end else begin : g_mid
      assign lv = q_v[i-1]; assign llt = q_lt[i-1]; assign lm = q_m[i-1];
      assign lw = q_w[i-1]; assign ltag = q_tag[i-1];
    end
    if (i == SYMBOLS - 1) begin : g_last
      assign rv = 1'b0; assign rm = 1'b0; assign rw = '0; assign rtag = '0;
    end else begin : g_inner
      assign rv = q_v[i+1]; assign rm = q_m[i+1];
      assign rw = q_w[i+1]; assign rtag = q_tag[i+1];
    end
    hfc_qcell #(.W_W(W_W), .N_W(N_W)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctrl(q_ctrl),
      .key_w(key_w), .key_m(key_m), .key_tag(key_tag),
      .lf_v(lv), .lf_w(lw), .lf_m(lm), .lf_tag(ltag), .lf_lt(llt),
      .rt_v(rv), .rt_w(rw), .rt_m(rm), .rt_tag(rtag),
      .cell_v(q_v[i]), .cell_w(q_w[i]), .cell_m(q_m[i]), .cell_tag(q_tag[i]),
      .cell_lt(q_lt[i])
    );
  end

  // code row, unloads toward cell 0
  for (genvar i = 0; i < SYMBOLS; i++) begin : g_c
    logic                     rv;
    logic [L_W-1:0]           rlen;
    logic [MAX_CODE_BITS-1:0] rbits;
    if (i == SYMBOLS - 1) begin : g_last
      assign rv = 1'b0; assign rlen = '0; assign rbits = '0;
    end else begin : g_inner
      assign rv = cc_v[i+1]; assign rlen = cc_len[i+1]; assign rbits = cc_bits[i+1];
    end
    hfc_ccell #(.N_W(N_W), .L_W(L_W), .C_W(MAX_CODE_BITS), .ID(i)) u_cell (
      .clk(clk), .ctrl(cc_ctrl),
      .mark_id(N_W'(ld_sym_r)), .a_id(a_r), .b_id(b_r), .m_id(m_id),
      .rt_v(rv), .rt_len(rlen), .rt_bits(rbits),
      .cell_v(cc_v[i]), .cell_len(cc_len[i]), .cell_bits(cc_bits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      built_r      <= 1'b0;
      any_leaf_r   <= 1'b0;
      root_r       <= '0;
      dn_r         <= '0;
      qn_r         <= '0;
      ld_pv_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r  <= op_t'(in_op);
            sym_r <= in_symbol;
            bit_r <= in_code_bit;
            case (op_t'(in_op))
              OP_COUNT: begin
                built_r <= 1'b0;
                state_r <= in_rng ? ST_CNT_RD : ST_IDLE;
              end
              OP_CLEAR: begin
                built_r    <= 1'b0;
                any_leaf_r <= 1'b0;
                root_r     <= '0;
                dn_r       <= '0;
              end
              OP_ENCODE: state_r <= built_r ? ST_ENC_RD : ST_B_INIT;
              OP_DECODE: state_r <= built_r ? ST_DEC_RD : ST_B_INIT;
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_CNT_RD: state_r <= ST_CNT_WR;
        ST_CNT_WR: state_r <= ST_IDLE;
        ST_B_INIT: begin
          qn_r       <= '0;
          ld_cnt_r   <= '0;
          k_r        <= '0;
          any_leaf_r <= 1'b0;
          ld_pv_r    <= 1'b0;
          state_r    <= ST_B_LOAD;
        end
        ST_B_LOAD: begin
          ld_pv_r  <= (ld_cnt_r < SYM_N);
          ld_sym_r <= ld_cnt_r[IDX_W-1:0];
          if (ld_cnt_r < SYM_N) begin
            ld_cnt_r <= ld_cnt_r + CNT_W'(1);
          end
          if (load_ins) begin
            qn_r       <= qn_r + CNT_W'(1);
            any_leaf_r <= 1'b1;
          end
          if (ld_cnt_r == SYM_N && !ld_pv_r) begin
            state_r <= ST_B_POPA;
          end
        end
        ST_B_POPA: begin
          if (qn_r > CNT_W'(1)) begin
            a_r     <= q_tag[0];
            wa_r    <= q_w[0];
            qn_r    <= qn_r - CNT_W'(1);
            state_r <= ST_B_POPB;
          end else begin
            root_r   <= (qn_r != '0) ? q_tag[0] : '0;
            dn_r     <= (qn_r != '0) ? q_tag[0] : '0;
            ul_cnt_r <= '0;
            state_r  <= ST_B_UNLOAD;
          end
        end
        ST_B_POPB: begin
          b_r     <= q_tag[0];
          w_r     <= wa_r + q_w[0];
          qn_r    <= qn_r - CNT_W'(1);
          state_r <= ST_B_INS;
        end
        ST_B_INS: begin
          qn_r    <= qn_r + CNT_W'(1);
          k_r     <= k_r + IDX_W'(1);
          state_r <= ST_B_POPA;
        end
        ST_B_UNLOAD: begin
          ul_cnt_r <= ul_cnt_r + CNT_W'(1);
          if (ul_cnt_r == SYM_N - CNT_W'(1)) begin
            built_r <= 1'b1;
            state_r <= (op_r == OP_ENCODE) ? ST_ENC_RD : ST_DEC_RD;
          end
        end
        ST_ENC_RD: state_r <= ST_ENC_OUT;
        ST_ENC_OUT: begin
          out_strobe_r <= 1'b1;
          out_dsym_r   <= '0;
          if (sym_rng && cq_v && cq_len != LEN_OVF) begin
            out_kind_r <= KIND_CODE;
            out_bits_r <= cq_bits;
            out_len_r  <= cq_len;
          end else begin
            out_kind_r <= KIND_ERR;
            out_bits_r <= '0;
            out_len_r  <= '0;
          end
          state_r <= ST_IDLE;
        end
        ST_DEC_RD: begin
          if (!any_leaf_r) begin
            state_r <= ST_IDLE;
          end else if (root_r < SYM_NODE) begin
            // one-symbol tree: every bit gives that symbol
            out_strobe_r <= 1'b1;
            out_kind_r   <= KIND_SYM;
            out_bits_r   <= '0;
            out_len_r    <= '0;
            out_dsym_r   <= SYM_W'(root_r);
            state_r      <= ST_IDLE;
          end else begin
            state_r <= ST_DEC_OUT;
          end
        end
        ST_DEC_OUT: begin
          if (nx < SYM_NODE) begin
            out_strobe_r <= 1'b1;
            out_kind_r   <= KIND_SYM;
            out_bits_r   <= '0;
            out_len_r    <= '0;
            out_dsym_r   <= SYM_W'(nx);
            dn_r         <= root_r;
          end else begin
            dn_r <= nx;
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_kind           = out_kind_r;
  assign out_code           = OUT_CODE_W'(out_bits_r);
  assign out_code_length    = OUT_LEN_W'(out_len_r);
  assign out_decoded_symbol = out_dsym_r;

  `ASSERT_IMP(a_qn_bound, busy, qn_r <= SYM_N)
  `ASSERT_IMP(a_ins_room, state_r == ST_B_INS, qn_r < SYM_N)
  `ASSERT_IMP(a_pop_valid, q_ctrl.pop, q_v[0])
  `ASSERT_IMP(a_code_len, out_strobe_r && out_kind_r == KIND_CODE, out_len_r < LEN_OVF)
  `ASSERT_NXT(a_dec_leaf, state_r == ST_DEC_OUT && nx < SYM_NODE, dn_r == root_r)

endmodule
